// File: hdl/rsac_pkg.sv
// Package for the RC stick arming controller.
// Holds the timer and mode types, stick thresholds and the saturating timer helpers.
// Used by rsac_decode, rsac_core and rc_stick_arming_controller.
`default_nettype none

package rsac_pkg;

  localparam int unsigned TIMER_BITS = 16;
  localparam int unsigned PWM_BITS   = 11;
  localparam int unsigned RAW_BITS   = 11;
  localparam int unsigned DT_BITS    = 10;
  localparam int unsigned MODE_BITS  = 3;
  localparam int unsigned NUM_MOTORS = 4;

  typedef logic [TIMER_BITS-1:0] timer_t;
  typedef logic [PWM_BITS-1:0]   pwm_t;
  typedef logic [RAW_BITS-1:0]   raw_t;
  typedef logic [DT_BITS-1:0]    dt_t;
  typedef logic [MODE_BITS-1:0]  mode_code_t;

  // Raw thresholds equivalent to the scaled stick tests, with the scaled value
  // s = trunc(7 * (raw - 1024) / 10): s > 400 is raw >= 1597, s < -400 is
  // raw <= 451 and s < -480 is raw <= 336.
  localparam raw_t RAW_HIGH_MIN  = RAW_BITS'(1597);
  localparam raw_t RAW_LOW_MAX   = RAW_BITS'(451);
  localparam raw_t RAW_FLOOR_MAX = RAW_BITS'(336);

  localparam logic [31:0] ARM_HOLD_MS    = 32'd2000;
  localparam logic [31:0] LOW_THR_MS     = 32'd2000;
  localparam logic [31:0] LOCK_HOLD_MS   = 32'd5000;
  localparam logic [31:0] SPIN_STEP1_MS  = 32'd400;
  localparam logic [31:0] SPIN_STEP2_MS  = 32'd800;
  localparam logic [31:0] SPIN_STEP3_MS  = 32'd1200;
  localparam logic [31:0] SPIN_STEP4_MS  = 32'd1600;
  localparam logic [31:0] SPIN_DONE_MS   = 32'd2000;

  localparam pwm_t IDLE_THROTTLE_RST = PWM_BITS'(150);

  typedef enum logic [4:0] {
    MODE_STOP  = 5'b00001,
    MODE_IDLE  = 5'b00010,
    MODE_WAIT  = 5'b00100,
    MODE_EMERG = 5'b01000,
    MODE_CALIB = 5'b10000
  } mode_e;

  localparam mode_code_t CODE_STOP  = 3'd0;
  localparam mode_code_t CODE_IDLE  = 3'd1;
  localparam mode_code_t CODE_WAIT  = 3'd2;
  localparam mode_code_t CODE_EMERG = 3'd3;
  localparam mode_code_t CODE_CALIB = 3'd4;

  typedef struct packed {
    logic arm;
    logic lock;
    logic calib;
    logic estop;
    logic stop;
    logic thr_floor;
  } gest_t;

  function automatic mode_code_t mode_code(mode_e m);
    mode_code_t c;
    case (m)
      MODE_STOP:  c = CODE_STOP;
      MODE_IDLE:  c = CODE_IDLE;
      MODE_WAIT:  c = CODE_WAIT;
      MODE_EMERG: c = CODE_EMERG;
      MODE_CALIB: c = CODE_CALIB;
      default:    c = CODE_STOP;
    endcase
    return c;
  endfunction

  function automatic timer_t t_add(timer_t t, dt_t dt);
    logic [TIMER_BITS:0] s;
    s = {1'b0, t} + (TIMER_BITS+1)'(dt);
    return s[TIMER_BITS] ? '1 : s[TIMER_BITS-1:0];
  endfunction

  function automatic timer_t t_sub(timer_t t, dt_t dt);
    timer_t d;
    d = TIMER_BITS'(dt);
    return (t > d) ? (t - d) : '0;
  endfunction

  function automatic logic [31:0] t_wide(timer_t t);
    return 32'(t);
  endfunction

endpackage

`default_nettype wire

// File: hdl/rsac_decode.sv
// Stick gesture decoder for the RC stick arming controller.
// Turns the raw receiver channels into gesture and switch flags.
// Depends on rsac_pkg.
`default_nettype none

module rsac_decode
  import rsac_pkg::*;
(
  input  raw_t  roll_raw_i,
  input  raw_t  pitch_raw_i,
  input  raw_t  throttle_raw_i,
  input  raw_t  yaw_raw_i,
  input  raw_t  estop_raw_i,
  input  raw_t  calib_raw_i,
  input  raw_t  stop_raw_i,
  output gest_t gest_o
);

  logic roll_hi, roll_lo, pitch_hi, pitch_lo, thr_hi, thr_lo, yaw_hi, yaw_lo;

  assign roll_hi  = roll_raw_i >= RAW_HIGH_MIN;
  assign roll_lo  = roll_raw_i <= RAW_LOW_MAX;
  assign pitch_hi = pitch_raw_i >= RAW_HIGH_MIN;
  assign pitch_lo = pitch_raw_i <= RAW_LOW_MAX;
  assign thr_hi   = throttle_raw_i >= RAW_HIGH_MIN;
  assign thr_lo   = throttle_raw_i <= RAW_LOW_MAX;
  assign yaw_hi   = yaw_raw_i >= RAW_HIGH_MIN;
  assign yaw_lo   = yaw_raw_i <= RAW_LOW_MAX;

  assign gest_o.arm       = thr_lo && yaw_hi && roll_lo && pitch_lo;
  assign gest_o.lock      = thr_hi && yaw_lo && roll_hi && pitch_hi;
  assign gest_o.calib     = thr_hi && yaw_lo && (calib_raw_i >= RAW_HIGH_MIN);
  assign gest_o.estop     = estop_raw_i >= RAW_HIGH_MIN;
  assign gest_o.stop      = stop_raw_i >= RAW_HIGH_MIN;
  assign gest_o.thr_floor = throttle_raw_i <= RAW_FLOOR_MAX;

endmodule

`default_nettype wire

// File: hdl/rsac_core.sv
// Arming state machine of the RC stick arming controller.
// Holds the lock flag, mode, timers and motor levels, and updates them once per request.
// Depends on rsac_pkg.
`default_nettype none

module rsac_core
  import rsac_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       step_i,
  input  dt_t        dt_i,
  input  gest_t      gest_i,
  input  pwm_t       idle_throttle_i,
  output logic       unlocked_o,
  output mode_code_t flight_mode_o,
  output pwm_t       motor_o [NUM_MOTORS]
);

  logic   unlocked_q, unlocked_d;
  mode_e  mode_q, mode_d;
  timer_t arm_q, arm_d, disarm_q, disarm_d, low_q, low_d, spin_q, spin_d;
  pwm_t   motor_q [NUM_MOTORS];
  pwm_t   motor_d [NUM_MOTORS];
  timer_t spin_t;

  always_comb begin
    unlocked_d = unlocked_q;
    mode_d     = mode_q;
    arm_d      = arm_q;
    disarm_d   = disarm_q;
    low_d      = low_q;
    spin_d     = spin_q;
    motor_d    = motor_q;
    spin_t     = '0;

    if (gest_i.estop) begin
      mode_d     = MODE_EMERG;
      unlocked_d = 1'b0;
    end else if (!unlocked_q) begin
      if (mode_q == MODE_STOP) begin
        if (gest_i.arm) begin
          arm_d = t_add(arm_q, dt_i);
          if (t_wide(arm_d) > ARM_HOLD_MS) begin
            unlocked_d = 1'b1;
            mode_d     = MODE_IDLE;
            arm_d      = '0;
            disarm_d   = '0;
            spin_d     = '0;
          end
        end else if (gest_i.calib) begin
          mode_d = MODE_CALIB;
        end else begin
          spin_d   = t_sub(spin_q, dt_i);
          disarm_d = t_sub(disarm_q, dt_i);
          low_d    = t_sub(low_q, dt_i);
        end
      end
    end else begin
      if (gest_i.arm) begin
        arm_d = t_add(arm_q, dt_i);
        if (t_wide(arm_d) > ARM_HOLD_MS) begin
          mode_d   = MODE_IDLE;
          arm_d    = '0;
          disarm_d = '0;
          spin_d   = '0;
        end
      end
      case (mode_d)
        MODE_IDLE: begin
          spin_t = t_add(spin_d, dt_i);
          if (t_wide(spin_t) < SPIN_STEP1_MS) begin
            motor_d[0] = idle_throttle_i;
          end else if (t_wide(spin_t) < SPIN_STEP2_MS) begin
            motor_d[1] = idle_throttle_i;
          end else if (t_wide(spin_t) < SPIN_STEP3_MS) begin
            motor_d[2] = idle_throttle_i;
          end else if (t_wide(spin_t) < SPIN_STEP4_MS) begin
            motor_d[3] = idle_throttle_i;
          end else if (t_wide(spin_t) > SPIN_DONE_MS) begin
            mode_d = MODE_WAIT;
            spin_t = '0;
          end
          spin_d = spin_t;
        end
        MODE_WAIT: begin
          if (gest_i.thr_floor) begin
            low_d = t_add(low_q, dt_i);
            if (t_wide(low_d) > LOW_THR_MS) begin
              mode_d = MODE_STOP;
              for (int i = 0; i < NUM_MOTORS; i++) motor_d[i] = '0;
              low_d = '0;
            end
          end
          if (gest_i.stop) begin
            mode_d = MODE_STOP;
            for (int i = 0; i < NUM_MOTORS; i++) motor_d[i] = '0;
          end
        end
        MODE_STOP: begin
          if (gest_i.lock) begin
            disarm_d = t_add(disarm_d, dt_i);
            if (t_wide(disarm_d) > LOCK_HOLD_MS) begin
              unlocked_d = 1'b0;
              for (int i = 0; i < NUM_MOTORS; i++) motor_d[i] = '0;
              arm_d    = '0;
              disarm_d = '0;
              spin_d   = '0;
            end
          end
        end
        default: begin
          spin_d   = t_sub(spin_d, dt_i);
          disarm_d = t_sub(disarm_d, dt_i);
          low_d    = t_sub(low_q, dt_i);
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      unlocked_q <= 1'b0;
      mode_q     <= MODE_STOP;
      arm_q      <= '0;
      disarm_q   <= '0;
      low_q      <= '0;
      spin_q     <= '0;
      for (int i = 0; i < NUM_MOTORS; i++) motor_q[i] <= '0;
    end else if (step_i) begin
      unlocked_q <= unlocked_d;
      mode_q     <= mode_d;
      arm_q      <= arm_d;
      disarm_q   <= disarm_d;
      low_q      <= low_d;
      spin_q     <= spin_d;
      motor_q    <= motor_d;
    end
  end

  assign unlocked_o    = unlocked_q;
  assign flight_mode_o = mode_code(mode_q);
  assign motor_o       = motor_q;

  a_mode_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(mode_q))
    else $error("mode register lost its one-hot code");

  a_emerg_latched: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mode_q == MODE_EMERG |=> mode_q == MODE_EMERG)
    else $error("emergency mode was left without reset");

  a_emerg_locked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q == MODE_EMERG || mode_q == MODE_CALIB) |-> !unlocked_q)
    else $error("emergency or calibration mode while unlocked");

  a_locked_motors_off: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!unlocked_q && (mode_q == MODE_STOP || mode_q == MODE_CALIB)) |->
      (motor_q[0] == '0 && motor_q[1] == '0 && motor_q[2] == '0 && motor_q[3] == '0))
    else $error("motor level held while locked and stopped");

endmodule

`default_nettype wire

// File: hdl/rc_stick_arming_controller.sv
// Top level of the RC stick arming controller.
// Input register with gesture decode, the arming state machine and the request handshakes.
// Depends on rsac_pkg, rsac_decode and rsac_core.
// The input register holds an accepted request; the core registers its result when it steps.
// Throughput: one request per cycle while out_stall_i does not hold a waiting result.
// The input register takes a new request while a finished result waits to be taken.
// Reset is asynchronous and active low: locked, motors stopped, timers and levels zero,
// idle throttle 150.
`default_nettype none

module rc_stick_arming_controller
  import rsac_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  dt_t        dt_ms_i,
  input  raw_t       roll_raw_i,
  input  raw_t       pitch_raw_i,
  input  raw_t       throttle_raw_i,
  input  raw_t       yaw_raw_i,
  input  raw_t       estop_raw_i,
  input  raw_t       calib_raw_i,
  input  raw_t       stop_raw_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic       unlocked_o,
  output mode_code_t flight_mode_o,
  output pwm_t       motor0_pwm_o,
  output pwm_t       motor1_pwm_o,
  output pwm_t       motor2_pwm_o,
  output pwm_t       motor3_pwm_o,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  pwm_t       cfg_idle_throttle_i
);

  logic  in_valid_q, out_valid_q, out_free, step, accept;
  gest_t gest, gest_q;
  dt_t   dt_q;
  pwm_t  idle_throttle_q;
  pwm_t  motor [NUM_MOTORS];

  rsac_decode u_decode (
    .roll_raw_i     (roll_raw_i),
    .pitch_raw_i    (pitch_raw_i),
    .throttle_raw_i (throttle_raw_i),
    .yaw_raw_i      (yaw_raw_i),
    .estop_raw_i    (estop_raw_i),
    .calib_raw_i    (calib_raw_i),
    .stop_raw_i     (stop_raw_i),
    .gest_o         (gest)
  );

  assign out_free    = !out_valid_q || !out_stall_i;
  assign step        = in_valid_q && out_free;
  assign in_stall_o  = in_valid_q && !out_free;
  assign accept      = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q      <= 1'b0;
      out_valid_q     <= 1'b0;
      idle_throttle_q <= IDLE_THROTTLE_RST;
    end else begin
      if (accept) begin
        in_valid_q <= 1'b1;
      end else if (step) begin
        in_valid_q <= 1'b0;
      end
      if (step) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        idle_throttle_q <= cfg_idle_throttle_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      gest_q <= gest;
      dt_q   <= dt_ms_i;
    end
  end

  rsac_core u_core (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .step_i          (step),
    .dt_i            (dt_q),
    .gest_i          (gest_q),
    .idle_throttle_i (idle_throttle_q),
    .unlocked_o      (unlocked_o),
    .flight_mode_o   (flight_mode_o),
    .motor_o         (motor)
  );

  assign out_valid_o  = out_valid_q;
  assign motor0_pwm_o = motor[0];
  assign motor1_pwm_o = motor[1];
  assign motor2_pwm_o = motor[2];
  assign motor3_pwm_o = motor[3];

endmodule

`default_nettype wire

// File: tb/rc_stick_arming_controller_tb.sv
// Self-checking testbench for rc_stick_arming_controller.
// Drives stick gesture sequences through the request handshakes and checks each
// result against a local model of the arming state machine; needs rsac_pkg and the RTL.
module rc_stick_arming_controller_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rsac_pkg::*;

  localparam int HOLD_ARM_MS   = 2000;
  localparam int HOLD_LOCK_MS  = 5000;
  localparam int HOLD_FLOOR_MS = 2000;
  localparam int SPIN_END_MS   = 2000;
  localparam int STICK_HI      = 400;
  localparam int THR_FLOOR     = -480;
  localparam int RAW_MAX       = 2047;
  localparam int RAW_CENTRE    = 1024;
  localparam int LOW_MAX       = 451;
  localparam int HIGH_MIN      = 1597;
  localparam int FLOOR_MAX     = 336;
  localparam int DT_MAX        = 1000;
  localparam int PWM_MAX       = 2000;
  localparam longint TIMER_CEIL = (longint'(1) << TIMER_BITS) - 1;

  typedef struct packed {
    dt_t  dt;
    raw_t roll;
    raw_t pitch;
    raw_t thr;
    raw_t yaw;
    raw_t estop;
    raw_t calib;
    raw_t stop;
  } tick_t;

  typedef struct packed {
    logic       unlocked;
    mode_code_t mode;
    pwm_t       m0;
    pwm_t       m1;
    pwm_t       m2;
    pwm_t       m3;
  } status_t;

  logic       clk_i;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_stall_o;
  dt_t        dt_ms_i;
  raw_t       roll_raw_i;
  raw_t       pitch_raw_i;
  raw_t       throttle_raw_i;
  raw_t       yaw_raw_i;
  raw_t       estop_raw_i;
  raw_t       calib_raw_i;
  raw_t       stop_raw_i;
  logic       out_valid_o;
  logic       out_stall_i;
  logic       unlocked_o;
  mode_code_t flight_mode_o;
  pwm_t       motor0_pwm_o;
  pwm_t       motor1_pwm_o;
  pwm_t       motor2_pwm_o;
  pwm_t       motor3_pwm_o;
  logic       cfg_valid_i;
  logic       cfg_ready_o;
  pwm_t       cfg_idle_throttle_i;

  logic       unlocked_now;
  mode_code_t mode_now;
  timer_t     arm_ms;
  timer_t     disarm_ms;
  timer_t     floor_ms;
  timer_t     spin_ms;
  pwm_t       motor_lvl [4];
  pwm_t       idle_pwm;

  status_t     pending_status_q [$];
  int unsigned items_sent;
  int unsigned mismatch_count;
  bit          in_idle_en;
  bit          out_idle_en;

  rc_stick_arming_controller i_dut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .in_valid_i          (in_valid_i),
    .in_stall_o          (in_stall_o),
    .dt_ms_i             (dt_ms_i),
    .roll_raw_i          (roll_raw_i),
    .pitch_raw_i         (pitch_raw_i),
    .throttle_raw_i      (throttle_raw_i),
    .yaw_raw_i           (yaw_raw_i),
    .estop_raw_i         (estop_raw_i),
    .calib_raw_i         (calib_raw_i),
    .stop_raw_i          (stop_raw_i),
    .out_valid_o         (out_valid_o),
    .out_stall_i         (out_stall_i),
    .unlocked_o          (unlocked_o),
    .flight_mode_o       (flight_mode_o),
    .motor0_pwm_o        (motor0_pwm_o),
    .motor1_pwm_o        (motor1_pwm_o),
    .motor2_pwm_o        (motor2_pwm_o),
    .motor3_pwm_o        (motor3_pwm_o),
    .cfg_valid_i         (cfg_valid_i),
    .cfg_ready_o         (cfg_ready_o),
    .cfg_idle_throttle_i (cfg_idle_throttle_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #10_000_000;
    $display("simulation failed");
    $finish;
  end

  function automatic int stick_pos(raw_t raw);
    int d;
    int v;
    d = int'(raw) - RAW_CENTRE;
    v = (7 * d) / 10;
    if (v > 500) v = 500;
    if (v < -500) v = -500;
    return v;
  endfunction

  function automatic timer_t sat_inc(timer_t t, dt_t dt);
    longint sum;
    sum = longint'(t) + longint'(dt);
    return (sum > TIMER_CEIL) ? timer_t'(TIMER_CEIL) : timer_t'(sum);
  endfunction

  function automatic timer_t sat_dec(timer_t t, dt_t dt);
    longint diff;
    diff = longint'(t) - longint'(dt);
    return (diff < 0) ? '0 : timer_t'(diff);
  endfunction

  function automatic void decay_timers(dt_t dt);
    spin_ms   = sat_dec(spin_ms, dt);
    disarm_ms = sat_dec(disarm_ms, dt);
    floor_ms  = sat_dec(floor_ms, dt);
  endfunction

  function automatic void arm_hold(dt_t dt);
    arm_ms = sat_inc(arm_ms, dt);
    if (arm_ms > HOLD_ARM_MS) begin
      unlocked_now = 1'b1;
      mode_now     = CODE_IDLE;
      arm_ms       = '0;
      disarm_ms    = '0;
      spin_ms      = '0;
    end
  endfunction

  function automatic status_t advance_controller(tick_t k);
    int      roll;
    int      pitch;
    int      thr;
    int      yaw;
    logic    arm_g;
    timer_t  t;
    status_t r;
    roll  = stick_pos(k.roll);
    pitch = stick_pos(k.pitch);
    thr   = stick_pos(k.thr);
    yaw   = stick_pos(k.yaw);
    arm_g = thr < -STICK_HI && yaw > STICK_HI && roll < -STICK_HI && pitch < -STICK_HI;
    if (stick_pos(k.estop) > STICK_HI) begin
      mode_now     = CODE_EMERG;
      unlocked_now = 1'b0;
    end else if (!unlocked_now) begin
      if (mode_now == CODE_STOP) begin
        if (arm_g) begin
          arm_hold(k.dt);
        end else if (thr > STICK_HI && yaw < -STICK_HI && stick_pos(k.calib) > STICK_HI) begin
          mode_now = CODE_CALIB;
        end else begin
          decay_timers(k.dt);
        end
      end
    end else begin
      if (arm_g) arm_hold(k.dt);
      if (mode_now == CODE_IDLE) begin
        t = sat_inc(spin_ms, k.dt);
        if (t < 400) motor_lvl[0] = idle_pwm;
        else if (t < 800) motor_lvl[1] = idle_pwm;
        else if (t < 1200) motor_lvl[2] = idle_pwm;
        else if (t < 1600) motor_lvl[3] = idle_pwm;
        else if (t > SPIN_END_MS) begin
          mode_now = CODE_WAIT;
          t = '0;
        end
        spin_ms = t;
      end else if (mode_now == CODE_WAIT) begin
        if (thr < THR_FLOOR) begin
          floor_ms = sat_inc(floor_ms, k.dt);
          if (floor_ms > HOLD_FLOOR_MS) begin
            mode_now  = CODE_STOP;
            motor_lvl = '{default: '0};
            floor_ms  = '0;
          end
        end
        if (stick_pos(k.stop) > STICK_HI) begin
          mode_now  = CODE_STOP;
          motor_lvl = '{default: '0};
        end
      end else if (mode_now == CODE_STOP) begin
        if (thr > STICK_HI && yaw < -STICK_HI && roll > STICK_HI && pitch > STICK_HI) begin
          disarm_ms = sat_inc(disarm_ms, k.dt);
          if (disarm_ms > HOLD_LOCK_MS) begin
            unlocked_now = 1'b0;
            motor_lvl    = '{default: '0};
            arm_ms       = '0;
            disarm_ms    = '0;
            spin_ms      = '0;
          end
        end
      end else begin
        decay_timers(k.dt);
      end
    end
    r.unlocked = unlocked_now;
    r.mode     = mode_now;
    r.m0       = motor_lvl[0];
    r.m1       = motor_lvl[1];
    r.m2       = motor_lvl[2];
    r.m3       = motor_lvl[3];
    return r;
  endfunction

  function automatic tick_t make_tick(int dt, int roll, int pitch, int thr, int yaw,
                                     int estop, int calib, int stop);
    tick_t k;
    k.dt    = dt_t'(dt);
    k.roll  = raw_t'(roll);
    k.pitch = raw_t'(pitch);
    k.thr   = raw_t'(thr);
    k.yaw   = raw_t'(yaw);
    k.estop = raw_t'(estop);
    k.calib = raw_t'(calib);
    k.stop  = raw_t'(stop);
    return k;
  endfunction

  function automatic int raw_in(int lo, int hi);
    return int'($urandom_range(hi, lo));
  endfunction

  // A calibration gesture while locked and stopped would hold until reset or estop, so the
  // calibration switch stays low there until the final phase.
  function automatic int safe_calib();
    return (!unlocked_now && mode_now == CODE_STOP) ? raw_in(0, HIGH_MIN - 1)
                                                    : raw_in(0, RAW_MAX);
  endfunction

  function automatic tick_t arm_tick(int dt_top);
    return make_tick(raw_in(0, dt_top), raw_in(0, LOW_MAX), raw_in(0, LOW_MAX),
                     raw_in(0, LOW_MAX), raw_in(HIGH_MIN, RAW_MAX), raw_in(0, HIGH_MIN - 1),
                     safe_calib(), raw_in(0, RAW_MAX));
  endfunction

  function automatic tick_t lock_tick(int dt_top);
    return make_tick(raw_in(0, dt_top), raw_in(HIGH_MIN, RAW_MAX), raw_in(HIGH_MIN, RAW_MAX),
                     raw_in(HIGH_MIN, RAW_MAX), raw_in(0, LOW_MAX), raw_in(0, HIGH_MIN - 1),
                     safe_calib(), raw_in(0, RAW_MAX));
  endfunction

  function automatic tick_t neutral_tick(int dt_top);
    return make_tick(raw_in(0, dt_top), raw_in(LOW_MAX + 1, HIGH_MIN - 1),
                     raw_in(LOW_MAX + 1, HIGH_MIN - 1), raw_in(LOW_MAX + 1, HIGH_MIN - 1),
                     raw_in(LOW_MAX + 1, HIGH_MIN - 1), raw_in(0, HIGH_MIN - 1),
                     safe_calib(), raw_in(0, HIGH_MIN - 1));
  endfunction

  function automatic tick_t noise_tick();
    return make_tick(raw_in(0, DT_MAX), raw_in(0, RAW_MAX), raw_in(0, RAW_MAX),
                     raw_in(0, RAW_MAX), raw_in(0, RAW_MAX), raw_in(0, HIGH_MIN - 1),
                     safe_calib(), raw_in(0, RAW_MAX));
  endfunction

  task automatic send_tick(input tick_t k);
    while (in_idle_en && $urandom_range(99) < 15) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    dt_ms_i        <= k.dt;
    roll_raw_i     <= k.roll;
    pitch_raw_i    <= k.pitch;
    throttle_raw_i <= k.thr;
    yaw_raw_i      <= k.yaw;
    estop_raw_i    <= k.estop;
    calib_raw_i    <= k.calib;
    stop_raw_i     <= k.stop;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    pending_status_q.push_back(advance_controller(k));
    items_sent++;
  endtask

  task automatic wait_all_results();
    in_valid_i <= 1'b0;
    while (pending_status_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_idle_throttle(input pwm_t value);
    wait_all_results();
    cfg_valid_i         <= 1'b1;
    cfg_idle_throttle_i <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    idle_pwm = value;
  endtask

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      mismatch_count++;
      if (mismatch_count <= 10)
        $display("%0t: %s mismatch, expected %0d, got %0d", $realtime, name, want, got);
    end
  endtask

  always @(posedge clk_i) begin : check_results
    status_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_status_q.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("%0t: result with no request outstanding", $realtime);
      end else begin
        want = pending_status_q.pop_front();
        check_field("unlocked", want.unlocked, unlocked_o);
        check_field("flight_mode", want.mode, flight_mode_o);
        check_field("motor0_pwm", want.m0, motor0_pwm_o);
        check_field("motor1_pwm", want.m1, motor1_pwm_o);
        check_field("motor2_pwm", want.m2, motor2_pwm_o);
        check_field("motor3_pwm", want.m3, motor3_pwm_o);
      end
    end
  end

  always @(posedge clk_i) begin
    out_stall_i <= out_idle_en && ($urandom_range(99) < 15);
  end

  task automatic test_stick_extremes();
    send_tick(make_tick(0, 0, 0, 0, 0, 0, 0, 0));
    send_tick(make_tick(DT_MAX, RAW_MAX, RAW_MAX, RAW_MAX, RAW_MAX, HIGH_MIN - 1,
                        RAW_MAX, RAW_MAX));
  endtask

  task automatic test_arm_hold();
    send_tick(make_tick(DT_MAX, LOW_MAX, LOW_MAX, LOW_MAX, HIGH_MIN, 0, 1024, 1024));
    // Releasing the gesture must not clear the time already held.
    send_tick(make_tick(DT_MAX, LOW_MAX + 1, LOW_MAX, LOW_MAX, HIGH_MIN, 0, 1024, 1024));
    send_tick(make_tick(DT_MAX, LOW_MAX, LOW_MAX, LOW_MAX, HIGH_MIN, 0, 1024, 1024));
    send_tick(make_tick(1, LOW_MAX, LOW_MAX, LOW_MAX, HIGH_MIN, 0, 1024, 1024));
  endtask

  task automatic test_spin_up();
    send_tick(make_tick(0, RAW_CENTRE, RAW_CENTRE, RAW_CENTRE, RAW_CENTRE, 0, 0, 0));
    repeat (5)
      send_tick(make_tick(400, RAW_CENTRE, RAW_CENTRE, RAW_CENTRE, RAW_CENTRE, 0, 0, 0));
    send_tick(make_tick(1, RAW_CENTRE, RAW_CENTRE, RAW_CENTRE, RAW_CENTRE, 0, 0, 0));
  endtask

  task automatic test_throttle_floor_stop();
    send_tick(make_tick(DT_MAX, RAW_CENTRE, RAW_CENTRE, FLOOR_MAX, RAW_CENTRE, 0, 0, 0));
    send_tick(make_tick(DT_MAX, RAW_CENTRE, RAW_CENTRE, FLOOR_MAX + 1, RAW_CENTRE, 0, 0, 0));
    send_tick(make_tick(DT_MAX, RAW_CENTRE, RAW_CENTRE, FLOOR_MAX, RAW_CENTRE, 0, 0, 0));
    send_tick(make_tick(1, RAW_CENTRE, RAW_CENTRE, FLOOR_MAX, RAW_CENTRE, 0, 0, 0));
  endtask

  task automatic test_lock_hold();
    repeat (5)
      send_tick(make_tick(DT_MAX, HIGH_MIN, HIGH_MIN, HIGH_MIN, LOW_MAX, 0, 0, 0));
    send_tick(make_tick(1, HIGH_MIN, HIGH_MIN, HIGH_MIN, LOW_MAX, 0, 0, 0));
  endtask

  task automatic test_random_flights(input int unsigned n_items);
    int unsigned stop_at;
    int unsigned guard;
    bit          by_switch;
    tick_t       k;
    stop_at = items_sent + n_items;
    while (items_sent < stop_at) begin
      guard = 0;
      while (mode_now != CODE_IDLE && guard < 40) begin
        if ($urandom_range(99) < 85) send_tick(arm_tick(700));
        else send_tick(noise_tick());
        guard++;
      end
      guard = 0;
      while (mode_now == CODE_IDLE && guard < 60) begin
        case ($urandom_range(9))
          0: send_tick(arm_tick(DT_MAX));
          1: send_tick(noise_tick());
          default: send_tick(neutral_tick(300));
        endcase
        guard++;
      end
      repeat ($urandom_range(4)) send_tick(neutral_tick(DT_MAX));
      by_switch = 1'($urandom_range(1));
      guard = 0;
      while (mode_now == CODE_WAIT && guard < 40) begin
        k = neutral_tick(800);
        if (by_switch) k.stop = raw_t'(raw_in(HIGH_MIN, RAW_MAX));
        else k.thr = raw_t'(raw_in(0, FLOOR_MAX));
        if ($urandom_range(99) < 12) send_tick(noise_tick());
        else send_tick(k);
        guard++;
      end
      if (mode_now == CODE_STOP && $urandom_range(9) < 7) begin
        guard = 0;
        while (unlocked_now && guard < 40) begin
          if ($urandom_range(9) == 0) send_tick(noise_tick());
          else send_tick(lock_tick(DT_MAX));
          guard++;
        end
      end
    end
  endtask

  task automatic test_calibration();
    int unsigned guard;
    tick_t       k;
    guard = 0;
    while ((unlocked_now || mode_now != CODE_STOP) && guard < 100) begin
      k = neutral_tick(DT_MAX);
      if (mode_now == CODE_WAIT) k.stop = raw_t'(RAW_MAX);
      else if (mode_now == CODE_STOP) k = lock_tick(DT_MAX);
      send_tick(k);
      guard++;
    end
    send_tick(make_tick(raw_in(0, DT_MAX), RAW_CENTRE, RAW_CENTRE, HIGH_MIN, LOW_MAX, 0,
                        HIGH_MIN, 0));
    send_tick(arm_tick(DT_MAX));
    send_tick(arm_tick(DT_MAX));
    send_tick(arm_tick(DT_MAX));
  endtask

  task automatic test_emergency(input int unsigned n_items);
    tick_t k;
    send_tick(make_tick(raw_in(0, DT_MAX), RAW_CENTRE, RAW_CENTRE, RAW_CENTRE, RAW_CENTRE,
                        HIGH_MIN, 0, 0));
    repeat (n_items) begin
      k = noise_tick();
      k.estop = raw_t'(raw_in(0, RAW_MAX));
      k.calib = raw_t'(raw_in(0, RAW_MAX));
      if ($urandom_range(3) == 0) k = arm_tick(DT_MAX);
      send_tick(k);
    end
  endtask

  initial begin
    rst_ni              <= 1'b0;
    in_valid_i          <= 1'b0;
    dt_ms_i             <= '0;
    roll_raw_i          <= '0;
    pitch_raw_i         <= '0;
    throttle_raw_i      <= '0;
    yaw_raw_i           <= '0;
    estop_raw_i         <= '0;
    calib_raw_i         <= '0;
    stop_raw_i          <= '0;
    cfg_valid_i         <= 1'b0;
    cfg_idle_throttle_i <= '0;
    unlocked_now   = 1'b0;
    mode_now       = CODE_STOP;
    arm_ms         = '0;
    disarm_ms      = '0;
    floor_ms       = '0;
    spin_ms        = '0;
    motor_lvl      = '{default: '0};
    idle_pwm       = pwm_t'(150);
    items_sent     = 0;
    mismatch_count = 0;
    in_idle_en     = 1'b1;
    out_idle_en    = 1'b1;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_stick_extremes();
    test_arm_hold();
    test_spin_up();
    test_throttle_floor_stop();
    test_lock_hold();

    write_idle_throttle(pwm_t'(PWM_MAX));
    test_random_flights(140);

    write_idle_throttle('0);
    in_idle_en  = 1'b0;
    out_idle_en = 1'b0;
    test_random_flights(140);
    in_idle_en  = 1'b1;
    out_idle_en = 1'b1;

    write_idle_throttle(pwm_t'($urandom_range(PWM_MAX - 1, 1)));
    test_random_flights(140);

    write_idle_throttle(pwm_t'($urandom_range(PWM_MAX, 0)));
    test_calibration();
    test_emergency(40);

    wait_all_results();
    repeat (8) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// File: sim.f
hdl/rsac_pkg.sv
hdl/rsac_decode.sv
hdl/rsac_core.sv
hdl/rc_stick_arming_controller.sv
tb/rc_stick_arming_controller_tb.sv
